[sv/bfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types, constants and helpers of the bitmap font text renderer.
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int unsigned SCREEN_WIDTH   = 320;
  localparam int unsigned GLYPH_COUNT    = 128;
  localparam int unsigned ROWS_PER_GLYPH = 16;
  localparam int unsigned COLS_PER_GLYPH = 8;
  localparam int unsigned INDEX_W        = 11;
  localparam int unsigned ROW_W          = $clog2(ROWS_PER_GLYPH);

  // font_index reaches 2047 at most, so the store never exceeds that span
  localparam int unsigned STORE_SPAN  = GLYPH_COUNT * ROWS_PER_GLYPH;
  localparam int unsigned STORE_DEPTH = (STORE_SPAN > (1 << INDEX_W)) ?
                                        (1 << INDEX_W) : STORE_SPAN;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [15:0]      SCREEN_W16 = 16'(SCREEN_WIDTH);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS_PER_GLYPH - 1);

  // request codes
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_CURSOR = 2'd1;
  localparam logic [1:0] REQ_DRAW   = 2'd2;

  // result kinds
  localparam logic KIND_ORIGIN = 1'b0;
  localparam logic KIND_ROW    = 1'b1;

  // register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [INDEX_W-1:0] font_index;
    logic [7:0]         font_bits;
    logic [15:0]        set_x;
    logic [15:0]        set_y;
    logic [6:0]         char_code;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] pix0;
    logic [15:0] pix1;
    logic [15:0] pix2;
    logic [15:0] pix3;
    logic [15:0] pix4;
    logic [15:0] pix5;
    logic [15:0] pix6;
    logic [15:0] pix7;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] fg;
    logic [15:0] bg;
  } colors_t;

  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } mem_req_t;

  // one font row to a row word; bit 7 is the leftmost pixel
  function automatic res_t row_word(input logic [7:0] bits, input colors_t c,
                                    input logic is_last);
    res_t r;
    r          = '0;
    r.kind     = KIND_ROW;
    r.pix0     = bits[7] ? c.fg : c.bg;
    r.pix1     = bits[6] ? c.fg : c.bg;
    r.pix2     = bits[5] ? c.fg : c.bg;
    r.pix3     = bits[4] ? c.fg : c.bg;
    r.pix4     = bits[3] ? c.fg : c.bg;
    r.pix5     = bits[2] ? c.fg : c.bg;
    r.pix6     = bits[1] ? c.fg : c.bg;
    r.pix7     = bits[0] ? c.fg : c.bg;
    r.last     = is_last;
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/bfr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_req_if / bfr_res_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface bfr_req_if
  import bfr_pkg::*;
  ;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bfr_res_if
  import bfr_pkg::*;
  ;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[sv/bfr_font_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_font_mem
// Font store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfr_font_mem
  import bfr_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t mreq,
  output logic [7:0]    rdata
);

  logic [7:0] store [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      store[mreq.waddr] <= mreq.wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (mreq.re) begin
      rdata <= store[mreq.raddr];
    end
  end

endmodule
`default_nettype wire

[sv/bfr_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_seq
// Request decode, cursor, glyph row sequencer and result register.
// ----------------------------------------------------------------------------
module bfr_seq
  import bfr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire colors_t colors,
  bfr_req_if.sink      req,
  bfr_res_if.source    res,
  output mem_req_t     mreq,
  input  wire logic [7:0] rdata
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ORIGIN = 2'd1;
  localparam logic [1:0] S_ROWS   = 2'd2;

  logic [1:0]       state;
  logic [15:0]      cursor_x;
  logic [15:0]      cursor_y;
  logic [6:0]       code;
  logic             oob;
  logic [ROW_W-1:0] row;
  logic             res_valid;
  res_t             res_data;

  logic             accept;
  logic             out_free;
  logic             load_origin;
  logic             load_row;
  logic             row_done;
  logic [ROW_W-1:0] rd_row;
  logic [INDEX_W-1:0] rd_full;
  logic [15:0]      nx;

  assign req.ready   = !rst && (state == S_IDLE);
  assign accept      = req.valid && req.ready;
  assign out_free    = !res_valid || res.ready;
  assign load_origin = (state == S_ORIGIN) && out_free;
  assign load_row    = (state == S_ROWS) && out_free;
  assign row_done    = load_row && (row == ROW_LAST);
  assign res.valid   = res_valid;
  assign res.payload = res_data;
  assign nx          = cursor_x + 16'(COLS_PER_GLYPH);

  // read of the next row goes out with each word loaded; data is ready next cycle
  assign rd_row  = load_origin ? '0 : ROW_W'(row + 1'b1);
  assign rd_full = INDEX_W'({code, rd_row});

  always_comb begin
    mreq       = '0;
    mreq.we    = accept && (req.payload.req_type == REQ_LOAD) &&
                 ({21'd0, req.payload.font_index} < STORE_DEPTH);
    mreq.waddr = req.payload.font_index[STORE_AW-1:0];
    mreq.wdata = req.payload.font_bits;
    mreq.re    = load_origin || (load_row && (row != ROW_LAST));
    mreq.raddr = rd_full[STORE_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor_x  <= '0;
      cursor_y  <= '0;
      res_valid <= 1'b0;
      row       <= '0;
    end else begin
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.payload.req_type == REQ_CURSOR) begin
              cursor_x <= req.payload.set_x;
              cursor_y <= req.payload.set_y;
            end else if (req.payload.req_type == REQ_DRAW &&
                         req.payload.char_code != '0) begin
              state <= S_ORIGIN;
            end
          end
        end
        S_ORIGIN: begin
          if (load_origin) begin
            res_valid <= 1'b1;
            row       <= '0;
            state     <= S_ROWS;
          end
        end
        S_ROWS: begin
          if (load_row) begin
            res_valid <= 1'b1;
            row       <= ROW_W'(row + 1'b1);
            if (row_done) begin
              state <= S_IDLE;
              if (nx >= SCREEN_W16) begin
                cursor_x <= '0;
                cursor_y <= cursor_y + 16'(ROWS_PER_GLYPH);
              end else begin
                cursor_x <= nx;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code <= req.payload.char_code;
      oob  <= ({25'd0, req.payload.char_code} >= GLYPH_COUNT);
    end
    if (load_origin) begin
      res_data <= '{kind: KIND_ORIGIN, origin_x: cursor_x, origin_y: cursor_y,
                    default: '0};
    end else if (load_row) begin
      res_data <= row_word(oob ? 8'd0 : rdata, colors, row == ROW_LAST);
    end
  end

  a_last_ends_glyph: assert property (@(posedge clk) disable iff (rst)
    row_done |=> (state == S_IDLE) && res.valid && res.payload.last)
    else $error("last row did not close the glyph");

  a_origin_clean: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.payload.kind == KIND_ORIGIN) |->
      (res.payload.last == 1'b0) && (res.payload.pix0 == '0) &&
      (res.payload.pix7 == '0))
    else $error("origin word carries pixel data");

  a_last_is_row: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.payload.last) |-> (res.payload.kind == KIND_ROW))
    else $error("last flag on an origin word");

  a_cursor_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_ORIGIN) |=> $stable(cursor_x) && $stable(cursor_y))
    else $error("cursor moved before the glyph was drawn");

endmodule
`default_nettype wire

[sv/bitmap_font_text_renderer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer_core
// 8x16 bitmap font text renderer with loadable font store and text cursor.
// ----------------------------------------------------------------------------
// A load word writes one font row byte (glyph code * 16 + row); a set-cursor
// word moves the cursor. A draw word with a nonzero code gives one origin
// word (the cursor) and then sixteen row words, top row first, pix0 leftmost,
// last set on the sixteenth. The sequencer issues one font store read per row
// word and loads one result word per cycle while the result side takes them;
// a stall on the result side holds it. A new word is accepted only once the
// previous draw has loaded its last row, while that row may still wait in the
// result register. Font entries never loaded read back as garbage; codes at
// or above the glyph count draw blank rows. After a glyph the cursor steps 8
// columns right and wraps to the next text line at the screen width. The font
// store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer_core
  import bfr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  bfr_req_if.sink                   req,
  bfr_res_if.source                 res
);

  colors_t    colors;
  mem_req_t   mreq;
  logic [7:0] rdata;

  // color registers; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      colors.fg <= 16'hFFFF;
      colors.bg <= 16'h0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FG:  colors.fg <= cfg_data;
        CFG_BG:  colors.bg <= cfg_data;
        default: ;
      endcase
    end
  end

  // font rows live here; written on load words, read by the sequencer
  bfr_font_mem u_mem (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  // decode, cursor, row sequencing and the result register
  bfr_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .colors (colors),
    .req    (req),
    .res    (res),
    .mreq   (mreq),
    .rdata  (rdata)
  );

endmodule
`default_nettype wire

[bench/bfr_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfr_checker
// Tracks font store, cursor and colors from accepted request words, predicts
// the origin and row words of each glyph and compares the result words.
// ----------------------------------------------------------------------------
module bfr_checker
  import bfr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  bfr_req_if                   req,
  bfr_res_if                   res,
  output int unsigned          words_due,
  output int unsigned          fail_count
);

  logic [7:0]  font_rows [STORE_DEPTH];
  logic [15:0] cur_x;
  logic [15:0] cur_y;
  logic [15:0] fg;
  logic [15:0] bg;
  res_t        glyph_words_due [$];

  initial begin
    words_due  = 0;
    fail_count = 0;
  end

  task automatic take_request(input req_t w);
    res_t        word;
    logic [7:0]  bits;
    logic [15:0] px [8];
    logic [15:0] nx;
    int          r;
    int          c;
    case (w.req_type)
      REQ_LOAD: begin
        if (w.font_index < STORE_DEPTH) font_rows[w.font_index] = w.font_bits;
      end
      REQ_CURSOR: begin
        cur_x = w.set_x;
        cur_y = w.set_y;
      end
      REQ_DRAW: begin
        if (w.char_code != '0) begin
          word          = '0;
          word.kind     = KIND_ORIGIN;
          word.origin_x = cur_x;
          word.origin_y = cur_y;
          glyph_words_due.push_back(word);
          for (r = 0; r < ROWS_PER_GLYPH; r++) begin
            if (w.char_code >= GLYPH_COUNT) bits = '0;
            else bits = font_rows[{w.char_code, ROW_W'(r)}];
            // bit 7 lands in the leftmost pixel
            for (c = 0; c < COLS_PER_GLYPH; c++) px[c] = bits[7 - c] ? fg : bg;
            word      = '0;
            word.kind = KIND_ROW;
            word.pix0 = px[0];
            word.pix1 = px[1];
            word.pix2 = px[2];
            word.pix3 = px[3];
            word.pix4 = px[4];
            word.pix5 = px[5];
            word.pix6 = px[6];
            word.pix7 = px[7];
            word.last = (r == ROWS_PER_GLYPH - 1);
            glyph_words_due.push_back(word);
          end
          nx = cur_x + 16'(COLS_PER_GLYPH);
          if (nx >= SCREEN_W16) begin
            nx    = '0;
            cur_y = cur_y + 16'(ROWS_PER_GLYPH);
          end
          cur_x = nx;
        end
      end
      default: ;
    endcase
  endtask

  function automatic bit word_differs(input res_t a, input res_t b);
    return (a.kind !== b.kind) || (a.origin_x !== b.origin_x) ||
           (a.origin_y !== b.origin_y) || (a.pix0 !== b.pix0) ||
           (a.pix1 !== b.pix1) || (a.pix2 !== b.pix2) || (a.pix3 !== b.pix3) ||
           (a.pix4 !== b.pix4) || (a.pix5 !== b.pix5) || (a.pix6 !== b.pix6) ||
           (a.pix7 !== b.pix7) || (a.last !== b.last);
  endfunction

  always @(posedge clk) begin
    res_t oldest;
    if (rst) begin
      glyph_words_due.delete();
      cur_x = '0;
      cur_y = '0;
      fg    = 16'hFFFF;
      bg    = 16'h0000;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FG:  fg = cfg_data;
          CFG_BG:  bg = cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) take_request(req.payload);
      if (res.valid && res.ready) begin
        if (glyph_words_due.size() == 0) begin
          if (fail_count < 10) $display("%0t: unexpected word %h", $time, res.payload);
          fail_count++;
        end else begin
          oldest = glyph_words_due.pop_front();
          if (word_differs(oldest, res.payload)) begin
            if (fail_count < 10)
              $display("%0t: mismatch (kind,x,y,pix0..7,last) exp %h got %h",
                       $time, oldest, res.payload);
            fail_count++;
          end
        end
      end
    end
    words_due <= glyph_words_due.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bitmap font text renderer core.
// ----------------------------------------------------------------------------
// A directed sweep loads one glyph with edge-case row patterns and draws it
// across the cursor wrap points, then random phases mix whole-glyph loads,
// stray loads, cursor moves, draws and ignored words under several color
// settings. Both channel sides idle at random; one phase runs with no idling
// and another holds the result side off long enough to back up the input.
// All checking lives in bfr_checker.
// ----------------------------------------------------------------------------
module tb_top
  import bfr_pkg::*;
;

  localparam int unsigned ITEM_GOAL    = 410;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 24;   // a bit over one full glyph
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam logic [1:0]  REQ_NONE     = 2'd3; // undefined request, ignored

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  bfr_req_if req_ch ();
  bfr_res_if res_ch ();

  int unsigned words_due;
  int unsigned fail_count;
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;
  int unsigned hold_cnt;
  bit          idle_on    = 1'b1;
  bit          hold_armed = 1'b0;
  logic [6:0]  loaded_codes [$];   // glyphs with all sixteen rows written

  bitmap_font_text_renderer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  bfr_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .res        (res_ch),
    .words_due  (words_due),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off when armed
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        res_ch.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
      end else begin
        res_ch.ready <= !(idle_on && $urandom_range(0, 99) < 33);
      end
    end
  end

  // every field random, so unused fields toggle too; callers override
  function automatic req_t noise_word();
    req_t w;
    w.req_type   = 2'($urandom_range(0, 3));
    w.font_index = INDEX_W'($urandom);
    w.font_bits  = 8'($urandom);
    w.set_x      = 16'($urandom);
    w.set_y      = 16'($urandom);
    w.char_code  = 7'($urandom);
    return w;
  endfunction

  // offer one word, with random gaps in front, and wait for acceptance;
  // valid stays high afterwards so back-to-back words need no extra edge
  task automatic send_word(input req_t w);
    while (idle_on && $urandom_range(0, 99) < 33) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= w;
    do @(posedge clk); while (!req_ch.ready);
    if (w.req_type != REQ_NONE && !(w.req_type == REQ_DRAW && w.char_code == '0))
      items_sent++;
  endtask

  task automatic load_row(input logic [INDEX_W-1:0] idx, input logic [7:0] bits);
    req_t w;
    w            = noise_word();
    w.req_type   = REQ_LOAD;
    w.font_index = idx;
    w.font_bits  = bits;
    send_word(w);
  endtask

  task automatic load_glyph(input logic [6:0] code);
    int r;
    for (r = 0; r < ROWS_PER_GLYPH; r++) load_row({code, ROW_W'(r)}, 8'($urandom));
    if (!(code inside {loaded_codes})) loaded_codes.push_back(code);
  endtask

  task automatic move_cursor(input logic [15:0] x, input logic [15:0] y);
    req_t w;
    w          = noise_word();
    w.req_type = REQ_CURSOR;
    w.set_x    = x;
    w.set_y    = y;
    send_word(w);
  endtask

  task automatic draw_char(input logic [6:0] code);
    req_t w;
    w           = noise_word();
    w.req_type  = REQ_DRAW;
    w.char_code = code;
    send_word(w);
  endtask

  // words the block must swallow: undefined request or the end code
  task automatic send_ignored();
    req_t w;
    w = noise_word();
    if ($urandom_range(0, 1)) begin
      w.req_type = REQ_NONE;
    end else begin
      w.req_type  = REQ_DRAW;
      w.char_code = '0;
    end
    send_word(w);
  endtask

  // colors change only with the block empty: drop valid, drain, write both
  task automatic recolor(input logic [15:0] fg, input logic [15:0] bg);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FG;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_index <= CFG_BG;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_sweep();
    logic [7:0] patterns [ROWS_PER_GLYPH];
    int r;
    patterns = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0,
                 8'h81, 8'h7E, 8'hC3, 8'h3C, 8'h18, 8'hE7, 8'h24, 8'hDB};
    for (r = 0; r < ROWS_PER_GLYPH; r++) load_row({7'd1, ROW_W'(r)}, patterns[r]);
    loaded_codes.push_back(7'd1);
    draw_char(7'd1);                           // cursor from reset, 0/0
    send_ignored();
    move_cursor(16'(SCREEN_WIDTH - 8), 16'hFFF0);
    draw_char(7'd1);                           // wraps x to 0, y wraps to 0
    move_cursor(16'hFFF8, 16'd5);
    draw_char(7'd1);                           // x overflows 16 bits to 0
    draw_char(7'd1);
    move_cursor(16'hFFFF, 16'hFFFF);
    draw_char(7'd1);
  endtask

  function automatic logic [15:0] pick_x();
    case ($urandom_range(0, 3))
      0:       return 16'(SCREEN_WIDTH - 8 * $urandom_range(1, 2));
      1:       return 16'($urandom_range(0, SCREEN_WIDTH));
      2:       return 16'hFFF8 + 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly draws of loaded glyphs, with loads, cursor moves and noise mixed in
  task automatic random_phase(input int unsigned goal);
    int unsigned pick;
    logic [6:0]  code;
    logic [15:0] y;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // first whole-glyph load takes the top code, so index 2047 is hit
        code = (loaded_codes.size() == 1) ? 7'h7F : 7'($urandom_range(0, 127));
        if (code == '0) load_glyph(7'd0); // row bytes of the end code only
        else load_glyph(code);
      end else if (pick < 18) begin
        load_row(INDEX_W'($urandom), 8'($urandom));
      end else if (pick < 30) begin
        y = $urandom_range(0, 1) ? 16'($urandom) : 16'hFFF0 + 16'($urandom_range(0, 15));
        move_cursor(pick_x(), y);
      end else if (pick < 38) begin
        send_ignored();
      end else begin
        draw_char(loaded_codes[$urandom_range(0, loaded_codes.size() - 1)]);
      end
    end
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_FG;
    cfg_data       <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    recolor(16'hFFFF, 16'h0000);
    directed_sweep();

    recolor(16'h0000, 16'hFFFF);
    random_phase(105);

    // no idling on either side
    recolor(16'($urandom), 16'($urandom));
    idle_on = 1'b0;
    random_phase(180);
    idle_on = 1'b1;

    // long result-side hold-off while draws keep coming
    recolor(16'hA5A5, 16'hA5A5);
    hold_armed = 1'b1;
    random_phase(255);

    recolor(16'($urandom), 16'($urandom));
    random_phase(330);

    recolor(16'h8000, 16'h0001);
    random_phase(ITEM_GOAL);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
sv/bfr_pkg.sv
sv/bfr_if.sv
sv/bfr_font_mem.sv
sv/bfr_seq.sv
sv/bitmap_font_text_renderer_core.sv
bench/bfr_checker.sv
bench/tb_top.sv
